/* hdl/pwcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pwcs_pkg;

  // Configuration port geometry: five registers, the widest is 16 bits.
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MUTE_ENABLE  = 3'd0,
    REG_SYNC_HIGH    = 3'd1,
    REG_SYNC_LOW     = 3'd2,
    REG_LONG_PULSE   = 3'd3,
    REG_SHORT_PULSE  = 3'd4
  } cfg_reg_t;

  // Values the registers take at reset.
  localparam logic [CFG_DATA_W-1:0] SYNC_HIGH_RST   = 16'd8000;
  localparam logic [CFG_DATA_W-1:0] SYNC_LOW_RST    = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] LONG_PULSE_RST  = 16'd1500;
  localparam logic [CFG_DATA_W-1:0] SHORT_PULSE_RST = 16'd500;

  // Kind of an input transaction.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PLAY = 1'b1
  } op_t;

  typedef struct packed {
    logic                  mute_enable;
    logic [CFG_DATA_W-1:0] sync_high_ticks;
    logic [CFG_DATA_W-1:0] sync_low_ticks;
    logic [CFG_DATA_W-1:0] long_pulse_ticks;
    logic [CFG_DATA_W-1:0] short_pulse_ticks;
  } cfg_t;

  // One result, in the order it is packed on the output bus (lowest bit last here).
  typedef struct packed {
    logic dropped;
    logic sending;
    logic line_level;
  } res_t;

endpackage

`default_nettype wire

/* hdl/pulse_width_command_sender.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Contents
// in_*      input      tuser: op (0 tick, 1 play); tdata: command, busy_level
// out_*     output     tdata: line_level, sending, dropped
// cfg_*     input      write enable, register index, 16-bit write data
//
// Every input transaction yields exactly one output transaction, after it has
// passed through the input register and then the result register.
// One transaction can be accepted every cycle while out_tready is high; the rate
// is set by the single pass through the frame sequencer between the two registers.
// Reset is synchronous and active low; it returns the line to low and idle and
// loads the default pulse timings.
// When out_tready is low, a held result stops the input register from moving
// and in_tready drops once the input register is full as well.
module pulse_width_command_sender #(
  parameter int COUNT_WIDTH  = 16,
  parameter int COMMAND_BITS = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  output      logic                                    in_tready,
  // Bits from the lowest: command, busy_level, zero fill.
  input  wire logic [((COMMAND_BITS + 8) / 8) * 8-1:0] in_tdata,
  // Bit 0: op.
  input  wire logic                                    in_tuser,
  output      logic                                    out_tvalid,
  input  wire logic                                    out_tready,
  // Bits from the lowest: line_level, sending, dropped, zero fill.
  output      logic [7:0]                              out_tdata,
  input  wire logic                                    cfg_wen,
  input  wire logic [pwcs_pkg::CFG_ADDR_W-1:0]         cfg_addr,
  input  wire logic [pwcs_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  // Input register.
  logic                    in_valid_r;
  logic                    op_r;
  logic [COMMAND_BITS-1:0] cmd_r;
  logic                    busy_r;

  // Result register.
  logic           out_valid_r;
  pwcs_pkg::res_t out_res_r;

  pwcs_pkg::cfg_t cfg;
  pwcs_pkg::res_t seq_res;

  logic advance;
  logic fire;
  logic in_accept;

  // The result register can take a new result when it is empty or being read.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_tuser;
      cmd_r  <= in_tdata[COMMAND_BITS-1:0];
      busy_r <= in_tdata[COMMAND_BITS];
    end
  end

  pwcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The sequencer steps exactly once per transaction, when it moves forward.
  pwcs_seq #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .COMMAND_BITS (COMMAND_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (fire),
    .op         (op_r),
    .command    (cmd_r),
    .busy_level (busy_r),
    .cfg        (cfg),
    .res        (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= seq_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r};

  // A transaction that moves forward always leaves a result behind it.
  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("result register not loaded after a step");

  // Only a play request can be reported as dropped.
  a_tick_never_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (pwcs_pkg::op_t'(op_r) == pwcs_pkg::OP_TICK)) |=> !out_res_r.dropped)
    else $error("tick transaction flagged as dropped");

  // The line is only driven high while a frame is in progress.
  a_line_high_only_sending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.line_level) |-> out_res_r.sending)
    else $error("line high outside a frame");

  // A request that was not dropped starts a frame.
  a_request_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (pwcs_pkg::op_t'(op_r) == pwcs_pkg::OP_PLAY) && !seq_res.dropped)
      |=> out_res_r.sending)
    else $error("accepted request did not start a frame");

endmodule

`default_nettype wire

/* hdl/pwcs_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

// Register file for the pulse timing and mute settings.
module pwcs_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wen,
  input  wire logic [pwcs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [pwcs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output pwcs_pkg::cfg_t                         cfg
);

  pwcs_pkg::cfg_t cfg_r;
  pwcs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      unique case (pwcs_pkg::cfg_reg_t'(cfg_addr))
        pwcs_pkg::REG_MUTE_ENABLE: cfg_nxt.mute_enable       = cfg_wdata[0];
        pwcs_pkg::REG_SYNC_HIGH:   cfg_nxt.sync_high_ticks   = cfg_wdata;
        pwcs_pkg::REG_SYNC_LOW:    cfg_nxt.sync_low_ticks    = cfg_wdata;
        pwcs_pkg::REG_LONG_PULSE:  cfg_nxt.long_pulse_ticks  = cfg_wdata;
        pwcs_pkg::REG_SHORT_PULSE: cfg_nxt.short_pulse_ticks = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mute_enable       <= 1'b0;
      cfg_r.sync_high_ticks   <= pwcs_pkg::SYNC_HIGH_RST;
      cfg_r.sync_low_ticks    <= pwcs_pkg::SYNC_LOW_RST;
      cfg_r.long_pulse_ticks  <= pwcs_pkg::LONG_PULSE_RST;
      cfg_r.short_pulse_ticks <= pwcs_pkg::SHORT_PULSE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* hdl/pwcs_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

// Frame sequencer. Holds the line state and advances it by one transaction
// whenever step_en is high. The result reflects the state after that step.
module pwcs_seq #(
  parameter int COUNT_WIDTH  = 16,
  parameter int COMMAND_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step_en,
  input  wire logic                    op,
  input  wire logic [COMMAND_BITS-1:0] command,
  input  wire logic                    busy_level,
  input  wire pwcs_pkg::cfg_t          cfg,
  output pwcs_pkg::res_t               res
);

  localparam int BIW  = (COMMAND_BITS > 1) ? $clog2(COMMAND_BITS) : 1;
  localparam int CMPW = (COUNT_WIDTH > pwcs_pkg::CFG_DATA_W) ? COUNT_WIDTH
                                                              : pwcs_pkg::CFG_DATA_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
  localparam logic [BIW-1:0]         LAST_BIT = BIW'(COMMAND_BITS - 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_SYNC_HI,
    PH_SYNC_LO,
    PH_BIT_HI,
    PH_BIT_LO
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic [BIW-1:0]          bidx_r, bidx_nxt;
  logic [COMMAND_BITS-1:0] shift_r, shift_nxt;
  logic                    line_r, line_nxt;

  logic                          cur_bit;
  logic [pwcs_pkg::CFG_DATA_W-1:0] part_len;
  logic [COUNT_WIDTH-1:0]        cnt_inc;
  logic                          part_done;
  logic                          dropped;

  assign cur_bit = shift_r[COMMAND_BITS-1];

  // Length of the part in progress; a one bit is long high, short low.
  always_comb begin
    case (phase_r)
      PH_SYNC_HI: part_len = cfg.sync_high_ticks;
      PH_SYNC_LO: part_len = cfg.sync_low_ticks;
      PH_BIT_HI:  part_len = cur_bit ? cfg.long_pulse_ticks : cfg.short_pulse_ticks;
      default:    part_len = cur_bit ? cfg.short_pulse_ticks : cfg.long_pulse_ticks;
    endcase
  end

  // The counter saturates; a part also ends when the counter is full.
  assign cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + COUNT_WIDTH'(1);
  assign part_done = (CMPW'(cnt_inc) >= CMPW'(part_len)) || (cnt_inc == CNT_MAX);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bidx_nxt  = bidx_r;
    shift_nxt = shift_r;
    line_nxt  = line_r;
    dropped   = 1'b0;
    if (step_en) begin
      if (pwcs_pkg::op_t'(op) == pwcs_pkg::OP_PLAY) begin
        if (cfg.mute_enable || (phase_r != PH_IDLE)) begin
          dropped = 1'b1;
        end else begin
          shift_nxt = command;
          bidx_nxt  = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_WAIT;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_WAIT: begin
            if (!busy_level) begin
              phase_nxt = PH_SYNC_HI;
              line_nxt  = 1'b1;
              cnt_nxt   = '0;
            end
          end
          PH_SYNC_HI, PH_SYNC_LO, PH_BIT_HI, PH_BIT_LO: begin
            cnt_nxt = cnt_inc;
            if (part_done) begin
              cnt_nxt = '0;
              case (phase_r)
                PH_SYNC_HI: begin
                  phase_nxt = PH_SYNC_LO;
                  line_nxt  = 1'b0;
                end
                PH_SYNC_LO, PH_BIT_LO: begin
                  if ((phase_r == PH_BIT_LO) && (bidx_r == LAST_BIT)) begin
                    phase_nxt = PH_IDLE;
                    line_nxt  = 1'b0;
                  end else begin
                    if (phase_r == PH_BIT_LO) begin
                      bidx_nxt  = bidx_r + BIW'(1);
                      shift_nxt = shift_r << 1;
                    end
                    phase_nxt = PH_BIT_HI;
                    line_nxt  = 1'b1;
                  end
                end
                default: begin
                  phase_nxt = PH_BIT_LO;
                  line_nxt  = 1'b0;
                end
              endcase
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bidx_r  <= '0;
      shift_r <= '0;
      line_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bidx_r  <= bidx_nxt;
      shift_r <= shift_nxt;
      line_r  <= line_nxt;
    end
  end

  assign res.line_level = line_nxt;
  assign res.sending    = (phase_nxt != PH_IDLE);
  assign res.dropped    = dropped;

endmodule

`default_nettype wire
